### rtl/sdiw_pkg.sv
// ---------------------------------------------------------------------------
// sdiw_pkg: shared types and constants of the disc indicator weights unit
// Word layouts of both channels, the flag group that runs down the chain,
// and the fixed-point constants of the weight arithmetic.
// ---------------------------------------------------------------------------
`default_nettype none

package sdiw_pkg;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] centre_x;
		logic signed [31:0] centre_y;
		logic        [30:0] disc_radius;
	} req_word_t;

	typedef struct packed {
		logic [16:0] volume_weight;
		logic [16:0] surface_weight;
	} rsp_word_t;

	typedef struct packed {
		logic neg;
		logic sat;
		logic nz;
	} flags_t;

	localparam int unsigned EXP_TERMS = 16;
	localparam int unsigned SQUARINGS = 5;
	localparam logic [31:0] ONE31     = 32'h8000_0000;
	localparam logic [30:0] GS_RESET  = 31'd65536;
	localparam logic [16:0] W_ONE     = 17'd65536;
	localparam logic [16:0] W_ZERO    = 17'd0;

endpackage

`default_nettype wire

### rtl/sdiw_sqrt_cell.sv
// ---------------------------------------------------------------------------
// sdiw_sqrt_cell: one digit cell of the square root chain
// Takes two radicand bits, tries the next root bit and hands remainder,
// partial root and the remaining radicand to the next cell.
// ---------------------------------------------------------------------------
`default_nettype none

module sdiw_sqrt_cell #(
	parameter int NW = 66,
	parameter int RW = 35,
	parameter int QW = 33,
	parameter int CW = 31
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          prev_valid,
	input  logic [RW-1:0] prev_rem,
	input  logic [QW-1:0] prev_root,
	input  logic [NW-1:0] prev_num,
	input  logic [CW-1:0] prev_carry,
	output logic          valid_q,
	output logic [RW-1:0] rem_q,
	output logic [QW-1:0] root_q,
	output logic [NW-1:0] num_q,
	output logic [CW-1:0] carry_q
);

	logic [RW+1:0] r2;
	logic [RW+1:0] trial;
	logic [RW+1:0] diff;
	logic          take;

	assign r2    = {prev_rem, prev_num[NW-1 -: 2]};
	assign trial = (RW+2)'({prev_root, 2'b01});
	assign take  = r2 >= trial;
	assign diff  = r2 - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_q   <= take ? diff[RW-1:0] : r2[RW-1:0];
			root_q  <= {prev_root[QW-2:0], take};
			num_q   <= {prev_num[NW-3:0], 2'b00};
			carry_q <= prev_carry;
		end
	end

endmodule

`default_nettype wire

### rtl/sdiw_div_cell.sv
// ---------------------------------------------------------------------------
// sdiw_div_cell: one bit cell of a restoring division chain
// Shifts in one dividend bit, subtracts the divisor when it fits and
// passes remainder, quotient and divisor on.
// ---------------------------------------------------------------------------
`default_nettype none

module sdiw_div_cell #(
	parameter int RW = 31,
	parameter int NW = 19,
	parameter int QW = 19,
	parameter int CW = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          prev_valid,
	input  logic [RW-1:0] prev_rem,
	input  logic [NW-1:0] prev_num,
	input  logic [QW-1:0] prev_quo,
	input  logic [RW-1:0] prev_div,
	input  logic [CW-1:0] prev_carry,
	output logic          valid_q,
	output logic [RW-1:0] rem_q,
	output logic [NW-1:0] num_q,
	output logic [QW-1:0] quo_q,
	output logic [RW-1:0] div_q,
	output logic [CW-1:0] carry_q
);

	logic [RW:0] r;
	logic [RW:0] diff;
	logic        take;

	assign r    = {prev_rem, prev_num[NW-1]};
	assign take = r >= {1'b0, prev_div};
	assign diff = r - {1'b0, prev_div};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_q   <= take ? diff[RW-1:0] : r[RW-1:0];
			num_q   <= {prev_num[NW-2:0], 1'b0};
			quo_q   <= {prev_quo[QW-2:0], take};
			div_q   <= prev_div;
			carry_q <= prev_carry;
		end
	end

endmodule

`default_nettype wire

### rtl/sdiw_exp_cell.sv
// ---------------------------------------------------------------------------
// sdiw_exp_cell: one term cell of the exponential series chain
// Multiplies the running term by y, divides by the term index K and
// adds or subtracts it from the running sum, over two stages.
// ---------------------------------------------------------------------------
`default_nettype none

module sdiw_exp_cell #(
	parameter int K  = 1,
	parameter int CW = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          prev_valid,
	input  logic [31:0]   prev_term,
	input  logic [31:0]   prev_sum,
	input  logic [30:0]   prev_y,
	input  logic [CW-1:0] prev_carry,
	output logic          valid_q,
	output logic [31:0]   term_q,
	output logic [31:0]   sum_q,
	output logic [30:0]   y_q,
	output logic [CW-1:0] carry_q
);

	localparam bit ODD = (K % 2) == 1;

	logic          valid_s1;
	logic [31:0]   p_s1;
	logic [31:0]   sum_s1;
	logic [30:0]   y_s1;
	logic [CW-1:0] carry_s1;
	logic [62:0]   prod;
	logic [31:0]   t;

	assign prod = 63'(prev_term) * 63'(prev_y);

	generate
		if ((K & (K - 1)) == 0) begin : g_shift
			localparam int SH = $clog2(K);
			assign t = p_s1 >> SH;
		end else begin : g_recip
			localparam logic [34:0] RECIP = 35'(((64'd1 << 35) + 64'(K) - 64'd1) / 64'(K));
			logic [66:0] pm;
			assign pm = 67'(p_s1) * 67'(RECIP);
			assign t  = pm[66:35];
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (adv) begin
			valid_s1 <= prev_valid;
			valid_q  <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1     <= prod[62:31];
			sum_s1   <= prev_sum;
			y_s1     <= prev_y;
			carry_s1 <= prev_carry;
			term_q   <= t;
			sum_q    <= ODD ? sum_s1 - t : sum_s1 + t;
			y_q      <= y_s1;
			carry_q  <= carry_s1;
		end
	end

endmodule

`default_nettype wire

### rtl/smoothed_disc_indicator_weights_unit.sv
// ---------------------------------------------------------------------------
// smoothed_disc_indicator_weights_unit: tanh-smoothed disc indicator weights
// Use: present a grid point, disc centre and radius on req_word with
// req_valid; the unit returns volume and surface weights (Q1.16) on
// rsp_word with rsp_valid, one word per request, in order.
// wr_en/wr_data load the grid spacing (Q15.16); load it while idle.
// Throughput: one word per cycle while no held word stalls the chain.
// The chain holds 33 square root cells, FRAC_BITS + 3 division cells,
// 16 two-stage series cells, 5 squarings, 31 cells of the final division
// and the front, distance, argument, weight and output registers.
// Reset clears all valid bits and loads a grid spacing of 1.0.
// When the receiver stalls with a word waiting, the whole chain holds and
// req_stall rises until the word is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module smoothed_disc_indicator_weights_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [30:0]         wr_data,
	input  logic                req_valid,
	output logic                req_stall,
	input  sdiw_pkg::req_word_t req_word,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output sdiw_pkg::rsp_word_t rsp_word
);

	import sdiw_pkg::*;

	localparam int QB    = FRAC_BITS + 3;
	localparam int YSH   = 26 - FRAC_BITS;
	localparam int SQ_N  = 33;
	localparam int SQ_NW = 66;
	localparam int SQ_RW = 35;
	localparam int QD_N  = 31;
	localparam int QD_RW = 33;
	localparam int FW    = $bits(flags_t);

	logic        adv;
	logic [30:0] gs_q;

	// front stages
	logic               valid_s1, valid_s2, valid_s3;
	logic [32:0]        ax_s1, ay_s1;
	logic [30:0]        rad_s1, rad_s2, rad_s3;
	logic [65:0]        axx_s2, ayy_s2, n_s3;
	logic signed [32:0] dx, dy;

	assign adv       = !(rsp_valid && rsp_stall);
	assign req_stall = !adv;

	assign dx = {req_word.point_x[31], req_word.point_x} - {req_word.centre_x[31], req_word.centre_x};
	assign dy = {req_word.point_y[31], req_word.point_y} - {req_word.centre_y[31], req_word.centre_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gs_q <= GS_RESET;
		end else if (wr_en) begin
			gs_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= req_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1  <= dx[32] ? 33'(-dx) : 33'(dx);
			ay_s1  <= dy[32] ? 33'(-dy) : 33'(dy);
			rad_s1 <= req_word.disc_radius;
			axx_s2 <= 66'(ax_s1) * 66'(ax_s1);
			ayy_s2 <= 66'(ay_s1) * 66'(ay_s1);
			rad_s2 <= rad_s1;
			n_s3   <= axx_s2 + ayy_s2;
			rad_s3 <= rad_s2;
		end
	end

	// square root chain
	logic             sq_v     [0:SQ_N];
	logic [SQ_RW-1:0] sq_rem   [0:SQ_N];
	logic [SQ_N-1:0]  sq_root  [0:SQ_N];
	logic [SQ_NW-1:0] sq_num   [0:SQ_N];
	logic [30:0]      sq_carry [0:SQ_N];

	assign sq_v[0]     = valid_s3;
	assign sq_rem[0]   = '0;
	assign sq_root[0]  = '0;
	assign sq_num[0]   = n_s3;
	assign sq_carry[0] = rad_s3;

	generate
		for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
			sdiw_sqrt_cell #(.NW(SQ_NW), .RW(SQ_RW), .QW(SQ_N), .CW(31)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.adv        (adv),
				.prev_valid (sq_v[i]),
				.prev_rem   (sq_rem[i]),
				.prev_root  (sq_root[i]),
				.prev_num   (sq_num[i]),
				.prev_carry (sq_carry[i]),
				.valid_q    (sq_v[i+1]),
				.rem_q      (sq_rem[i+1]),
				.root_q     (sq_root[i+1]),
				.num_q      (sq_num[i+1]),
				.carry_q    (sq_carry[i+1])
			);
		end
	endgenerate

	// signed distance and saturation
	logic        valid_s4;
	logic [32:0] mag_s4;
	logic        neg_s4, sat_s4;
	logic [32:0] len, rad_x, mag;
	logic        neg, sat;

	assign len   = sq_root[SQ_N];
	assign rad_x = 33'(sq_carry[SQ_N]);
	assign neg   = len > rad_x;
	assign mag   = neg ? len - rad_x : rad_x - len;
	assign sat   = (gs_q == '0) ? (mag != '0) : (34'(mag) >= {gs_q, 3'b000});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= sq_v[SQ_N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s4 <= mag;
			neg_s4 <= neg;
			sat_s4 <= sat;
		end
	end

	// scaled distance division chain
	logic          dv_v     [0:QB];
	logic [30:0]   dv_rem   [0:QB];
	logic [QB-1:0] dv_num   [0:QB];
	logic [QB-1:0] dv_quo   [0:QB];
	logic [30:0]   dv_div   [0:QB];
	logic [1:0]    dv_carry [0:QB];

	assign dv_v[0]     = valid_s4;
	assign dv_rem[0]   = {1'b0, mag_s4[32:3]};
	assign dv_num[0]   = QB'(mag_s4[2:0]) << FRAC_BITS;
	assign dv_quo[0]   = '0;
	assign dv_div[0]   = gs_q;
	assign dv_carry[0] = {neg_s4, sat_s4};

	generate
		for (genvar i = 0; i < QB; i++) begin : g_dist
			sdiw_div_cell #(.RW(31), .NW(QB), .QW(QB), .CW(2)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.adv        (adv),
				.prev_valid (dv_v[i]),
				.prev_rem   (dv_rem[i]),
				.prev_num   (dv_num[i]),
				.prev_quo   (dv_quo[i]),
				.prev_div   (dv_div[i]),
				.prev_carry (dv_carry[i]),
				.valid_q    (dv_v[i+1]),
				.rem_q      (dv_rem[i+1]),
				.num_q      (dv_num[i+1]),
				.quo_q      (dv_quo[i+1]),
				.div_q      (dv_div[i+1]),
				.carry_q    (dv_carry[i+1])
			);
		end
	endgenerate

	// series argument
	logic          valid_s5;
	logic [30:0]   y_s5;
	flags_t        flags_s5;
	logic [QB-1:0] dq;

	assign dq = (dv_div[QB] == '0) ? '0 : dv_quo[QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s5 <= dv_v[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			y_s5         <= 31'({dq, 2'b00}) << YSH;
			flags_s5.neg <= dv_carry[QB][1];
			flags_s5.sat <= dv_carry[QB][0];
			flags_s5.nz  <= dq != '0;
		end
	end

	// exponential series chain
	logic          ex_v     [0:EXP_TERMS];
	logic [31:0]   ex_term  [0:EXP_TERMS];
	logic [31:0]   ex_sum   [0:EXP_TERMS];
	logic [30:0]   ex_y     [0:EXP_TERMS];
	logic [FW-1:0] ex_carry [0:EXP_TERMS];

	assign ex_v[0]     = valid_s5;
	assign ex_term[0]  = ONE31;
	assign ex_sum[0]   = ONE31;
	assign ex_y[0]     = y_s5;
	assign ex_carry[0] = flags_s5;

	generate
		for (genvar i = 0; i < EXP_TERMS; i++) begin : g_exp
			sdiw_exp_cell #(.K(i + 1), .CW(FW)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.adv        (adv),
				.prev_valid (ex_v[i]),
				.prev_term  (ex_term[i]),
				.prev_sum   (ex_sum[i]),
				.prev_y     (ex_y[i]),
				.prev_carry (ex_carry[i]),
				.valid_q    (ex_v[i+1]),
				.term_q     (ex_term[i+1]),
				.sum_q      (ex_sum[i+1]),
				.y_q        (ex_y[i+1]),
				.carry_q    (ex_carry[i+1])
			);
		end
	endgenerate

	// repeated squaring
	logic          pw_v     [0:SQUARINGS];
	logic [31:0]   pw_e     [0:SQUARINGS];
	logic [FW-1:0] pw_carry [0:SQUARINGS];

	assign pw_v[0]     = ex_v[EXP_TERMS];
	assign pw_e[0]     = ex_sum[EXP_TERMS];
	assign pw_carry[0] = ex_carry[EXP_TERMS];

	generate
		for (genvar j = 0; j < SQUARINGS; j++) begin : g_pow
			logic [63:0] sq;
			assign sq = 64'(pw_e[j]) * 64'(pw_e[j]);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					pw_v[j+1] <= 1'b0;
				end else if (adv) begin
					pw_v[j+1] <= pw_v[j];
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					pw_e[j+1]     <= sq[62:31];
					pw_carry[j+1] <= pw_carry[j];
				end
			end
		end
	endgenerate

	// logistic quotient e / (1 + e)
	logic             qd_v     [0:QD_N];
	logic [QD_RW-1:0] qd_rem   [0:QD_N];
	logic [QD_N-1:0]  qd_num   [0:QD_N];
	logic [QD_N-1:0]  qd_quo   [0:QD_N];
	logic [QD_RW-1:0] qd_div   [0:QD_N];
	logic [FW-1:0]    qd_carry [0:QD_N];

	assign qd_v[0]     = pw_v[SQUARINGS];
	assign qd_rem[0]   = QD_RW'(pw_e[SQUARINGS]);
	assign qd_num[0]   = '0;
	assign qd_quo[0]   = '0;
	assign qd_div[0]   = QD_RW'(ONE31) + QD_RW'(pw_e[SQUARINGS]);
	assign qd_carry[0] = pw_carry[SQUARINGS];

	generate
		for (genvar i = 0; i < QD_N; i++) begin : g_logit
			sdiw_div_cell #(.RW(QD_RW), .NW(QD_N), .QW(QD_N), .CW(FW)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.adv        (adv),
				.prev_valid (qd_v[i]),
				.prev_rem   (qd_rem[i]),
				.prev_num   (qd_num[i]),
				.prev_quo   (qd_quo[i]),
				.prev_div   (qd_div[i]),
				.prev_carry (qd_carry[i]),
				.valid_q    (qd_v[i+1]),
				.rem_q      (qd_rem[i+1]),
				.num_q      (qd_num[i+1]),
				.quo_q      (qd_quo[i+1]),
				.div_q      (qd_div[i+1]),
				.carry_q    (qd_carry[i+1])
			);
		end
	endgenerate

	// weights
	logic        valid_s6;
	logic [31:0] v31_s6;
	logic [61:0] prod_s6;
	flags_t      flags_s6;
	flags_t      fq;
	logic [31:0] q32, qc;
	logic [32:0] vol_r;
	logic [62:0] surf_r;

	assign fq     = qd_carry[QD_N];
	assign q32    = 32'(qd_quo[QD_N]);
	assign qc     = ONE31 - q32;
	assign vol_r  = 33'(v31_s6) + 33'(1 << 14);
	assign surf_r = 63'(prod_s6) + (63'd1 << 43);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6  <= 1'b0;
			rsp_valid <= 1'b0;
		end else if (adv) begin
			valid_s6  <= qd_v[QD_N];
			rsp_valid <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v31_s6   <= (fq.neg && fq.nz) ? q32 : qc;
			prod_s6  <= 62'(q32) * 62'(qc);
			flags_s6 <= fq;
			if (flags_s6.sat) begin
				rsp_word.volume_weight  <= flags_s6.neg ? W_ZERO : W_ONE;
				rsp_word.surface_weight <= W_ZERO;
			end else begin
				rsp_word.volume_weight  <= vol_r[31:15];
				rsp_word.surface_weight <= surf_r[60:44];
			end
		end
	end

	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_word.volume_weight <= W_ONE && rsp_word.surface_weight <= W_ONE))
		else $error("weight above one");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (rsp_valid && rsp_stall))
		else $error("request stalled without a held response");

	a_hold_tail: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(valid_s6) && $stable(v31_s6))
		else $error("chain moved while held");

	a_sat_surface: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && valid_s6 && flags_s6.sat) |=> (rsp_word.surface_weight == W_ZERO))
		else $error("saturated word with nonzero surface weight");

endmodule

`default_nettype wire

### dv/sdiw_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sdiw_checker: response checker of the disc indicator weights unit
// Watches the spacing register and both channels, works out the weights of
// every accepted request and compares each accepted response, field by field,
// with the oldest outstanding expectation.
// ---------------------------------------------------------------------------

module sdiw_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [30:0]         wr_data,
	input  logic                req_valid,
	input  logic                req_stall,
	input  sdiw_pkg::req_word_t req_word,
	input  logic                rsp_valid,
	input  logic                rsp_stall,
	input  sdiw_pkg::rsp_word_t rsp_word,
	output int                  fail_count,
	output int                  pending_count
);
	import sdiw_pkg::*;

	localparam int FRAC = 16;
	localparam longint unsigned Q31 = 64'h8000_0000;

	logic [30:0] spacing;
	rsp_word_t   weights_due[$];

	function automatic rsp_word_t disc_weights(req_word_t w, logic [30:0] gs);
		longint dx, dy;
		longint unsigned ax, ay, len, mag, dq, y, sum, term, q, v31;
		logic [67:0] n, c;
		logic neg;
		rsp_word_t r;
		dx = longint'(w.point_x) - longint'(w.centre_x);
		dy = longint'(w.point_y) - longint'(w.centre_y);
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		n = 68'(ax) * 68'(ax) + 68'(ay) * 68'(ay);
		len = 0;
		for (int b = 32; b >= 0; b--) begin
			c = 68'(len) | (68'd1 << b);
			if (c * c <= n)
				len = c[63:0];
		end
		neg = len > 64'(w.disc_radius);
		mag = neg ? len - 64'(w.disc_radius) : 64'(w.disc_radius) - len;
		if (gs == 0) begin
			if (mag != 0) begin
				r.volume_weight = neg ? W_ZERO : W_ONE;
				r.surface_weight = W_ZERO;
				return r;
			end
			dq = 0;
		end else begin
			dq = (mag << FRAC) / 64'(gs);
			if (dq >= (64'd8 << FRAC)) begin
				r.volume_weight = neg ? W_ZERO : W_ONE;
				r.surface_weight = W_ZERO;
				return r;
			end
		end
		y = (4 * dq) << (26 - FRAC);
		sum = Q31;
		term = Q31;
		for (int k = 1; k <= EXP_TERMS; k++) begin
			term = ((term * y) >> 31) / longint'(k);
			if (k % 2) sum = sum - term;
			else sum = sum + term;
		end
		for (int i = 0; i < SQUARINGS; i++)
			sum = (sum * sum) >> 31;
		q = (sum << 31) / (Q31 + sum);
		v31 = (neg && dq != 0) ? q : Q31 - q;
		r.volume_weight = 17'((v31 + (64'd1 << 14)) >> 15);
		r.surface_weight = 17'((q * (Q31 - q) + (64'd1 << 43)) >> 44);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_word_t due;
		if (!arst_n) begin
			spacing <= GS_RESET;
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			if (wr_en)
				spacing <= wr_data;
			if (req_valid && !req_stall)
				weights_due.push_back(disc_weights(req_word, spacing));
			if (rsp_valid && !rsp_stall) begin
				if (weights_due.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected word: vol %0d surf %0d",
							rsp_word.volume_weight, rsp_word.surface_weight);
					fail_count <= fail_count + 1;
				end else begin
					due = weights_due.pop_front();
					if (due.volume_weight !== rsp_word.volume_weight ||
						due.surface_weight !== rsp_word.surface_weight) begin
						if (fail_count < 10)
							$display("mismatch: vol exp %0d got %0d, surf exp %0d got %0d",
								due.volume_weight, rsp_word.volume_weight,
								due.surface_weight, rsp_word.surface_weight);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending_count <= weights_due.size();
		end
	end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: testbench of the disc indicator weights unit
// Drives directed and random disc queries under several grid spacings with
// random gaps and stalls, a long output hold and a drain pause; the checker
// beside the unit predicts and compares every response word.
// ---------------------------------------------------------------------------

module tb_top;
	import sdiw_pkg::*;

	localparam int LATENCY = 140;
	localparam int WATCHDOG = 20000;

	logic      clk = 0;
	logic      arst_n = 0;
	logic      wr_en = 0;
	logic [30:0] wr_data = '0;
	logic      req_valid = 0;
	logic      req_stall;
	req_word_t req_word = '0;
	logic      rsp_valid;
	logic      rsp_stall = 0;
	rsp_word_t rsp_word;
	int        fail_count, pending_count;
	bit        quiet = 0;
	bit        long_hold = 0;
	int        idle_cycles = 0;
	logic [30:0] spacing_now = GS_RESET;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	smoothed_disc_indicator_weights_unit dut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_data(wr_data),
		.req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
	);

	sdiw_checker chk (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_data(wr_data),
		.req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	// hold off the output side in bursts, or for one long stretch on request
	initial begin
		int burst;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				rsp_stall = 1;
				for (int i = 0; i < 400; i++) @(negedge clk);
				rsp_stall = 0;
				long_hold = 0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 12);
				rsp_stall = 1;
				for (int i = 1; i < burst; i++) @(negedge clk);
				@(negedge clk);
				rsp_stall = 0;
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send_query(req_word_t w);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 12);
			req_valid = 0;
			repeat (gap) @(negedge clk);
		end
		req_valid = 1;
		req_word = w;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	task automatic go_idle();
		req_valid = 0;
		while (pending_count != 0) @(negedge clk);
		repeat (LATENCY) @(negedge clk);
	endtask

	task automatic load_spacing(logic [30:0] gs);
		wr_en = 1;
		wr_data = gs;
		spacing_now = gs;
		@(negedge clk);
		wr_en = 0;
	endtask

	function automatic req_word_t disc_query(int px, int py, int cx, int cy,
		logic [30:0] r);
		req_word_t w;
		w.point_x = px;
		w.point_y = py;
		w.centre_x = cx;
		w.centre_y = cy;
		w.disc_radius = r;
		return w;
	endfunction

	// point near the rim so the weights leave saturation most of the time
	function automatic req_word_t rim_query();
		req_word_t w;
		int shift;
		longint dx, dy, r;
		real len, band;
		w.centre_x = $urandom;
		w.centre_y = $urandom;
		shift = $urandom_range(0, 30);
		dx = longint'($signed($urandom)) >>> (31 - shift);
		dy = longint'($signed($urandom)) >>> (31 - shift);
		w.point_x = w.centre_x + int'(dx);
		w.point_y = w.centre_y + int'(dy);
		dx = longint'(w.point_x) - longint'(w.centre_x);
		dy = longint'(w.point_y) - longint'(w.centre_y);
		len = $sqrt(real'(dx) * real'(dx) + real'(dy) * real'(dy));
		band = 10.0 * real'(spacing_now == 0 ? 1 : spacing_now);
		r = longint'(len + ($urandom_range(0, 2000) / 1000.0 - 1.0) * band);
		if ($urandom_range(0, 9) == 0) r = longint'(len) + $urandom_range(0, 3) - 1;
		if (r < 0) r = 0;
		if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
		w.disc_radius = 31'(r);
		return w;
	endfunction

	task automatic random_queries(int count);
		req_word_t w;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				w.point_x = $urandom;
				w.point_y = $urandom;
				w.centre_x = $urandom;
				w.centre_y = $urandom;
				w.disc_radius = 31'($urandom);
			end else
				w = rim_query();
			send_query(w);
		end
	endtask

	initial begin
		logic [30:0] spacings[6];
		spacings = '{31'd1, 31'h7FFF_FFFF, 31'd0, 31'd32768, 31'd1 << 22, 31'd65536};
		repeat (11) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send_query(disc_query(0, 0, 0, 0, 31'd0));
		send_query(disc_query(0, 0, 0, 0, 31'h7FFF_FFFF));
		send_query(disc_query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh8000_0000, 32'sh8000_0000, 31'd0));
		send_query(disc_query(32'sh8000_0000, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF));
		send_query(disc_query(32'sh8000_0000, 0, 32'sh7FFF_FFFF, 0, 31'h7FFF_FFFF));
		send_query(disc_query(3 << 16, 4 << 16, 0, 0, 31'(5 << 16)));
		send_query(disc_query(3 << 16, 4 << 16, 0, 0, 31'((5 << 16) + 1)));
		send_query(disc_query(3 << 16, 4 << 16, 0, 0, 31'((5 << 16) - 1)));
		send_query(disc_query(3 << 16, 4 << 16, 0, 0, 31'(13 << 16)));
		send_query(disc_query(3 << 16, 4 << 16, 0, 0, 31'(14 << 16)));
		send_query(disc_query(3 << 16, 4 << 16, 0, 0, 0));
		send_query(disc_query(8 << 16, 0, 0, 0, 0));
		send_query(disc_query(8 << 16, 0, 0, 0, 31'(1 << 14)));
		send_query(disc_query(-(1 << 16), 0, 0, 0, 31'(3 << 15)));
		send_query(disc_query(0, -(1 << 16), 0, 0, 31'(1 << 15)));
		send_query(disc_query(100, 100, 100, 100, 31'(1 << 17)));
		send_query(disc_query(1, 1, -1, -1, 31'd2));
		send_query(disc_query(1 << 20, 0, 0, 0, 31'((1 << 20) - (1 << 18))));
		random_queries(100);

		// fill the pipe against a long output hold
		long_hold = 1;
		random_queries(200);
		go_idle();

		for (int p = 0; p < 6; p++) begin
			load_spacing(spacings[p]);
			if (p == 5) quiet = 1;
			send_query(disc_query(0, 0, 0, 0, 31'd0));
			send_query(disc_query(1 << 16, 0, 0, 0, 31'(1 << 16)));
			send_query(disc_query(1 << 16, 0, 0, 0, 31'((1 << 16) - 1)));
			send_query(disc_query(1 << 16, 0, 0, 0, 31'((1 << 16) + 1)));
			random_queries(p == 1 ? 60 : 90);
			go_idle();
		end

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### sim.f
rtl/sdiw_pkg.sv
rtl/sdiw_sqrt_cell.sv
rtl/sdiw_div_cell.sv
rtl/sdiw_exp_cell.sv
rtl/smoothed_disc_indicator_weights_unit.sv
dv/sdiw_checker.sv
dv/tb_top.sv
